@@ rtl/srr_pkg.sv @@
// srr_pkg: types and constants shared by the selective-repeat receiver
// no dependencies
`timescale 1ns / 1ps

package srr_pkg;

  localparam int SEQ_W  = 3;
  localparam int DATA_W = 64;

  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  typedef struct packed {
    logic              checksum_ok;
    logic [SEQ_W-1:0]  seq_num;
    logic [DATA_W-1:0] payload_word;
  } in_item_t;

  typedef struct packed {
    logic              result_kind;
    logic [SEQ_W-1:0]  ack_number;
    logic [DATA_W-1:0] delivered_data;
    logic              last_of_run;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACK,
    ST_DELIVER
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic shift;
    logic sel_data;
  } srr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic at_base;
    logic run_end;
  } srr_status_t;

endpackage

@@ rtl/srr_ctrl.sv @@
// srr_ctrl: sequencing of acknowledgment and in-order delivery transfers
// depends on srr_pkg
`timescale 1ns / 1ps

module srr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                checksum_ok,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output srr_pkg::srr_cmd_t   cmd,
  input  srr_pkg::srr_status_t status
);
  import srr_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_stall     = 1'b1;
    out_valid    = 1'b0;
    cmd.capture  = 1'b0;
    cmd.shift    = 1'b0;
    cmd.sel_data = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        // a corrupted packet is taken and dropped
        if (in_valid && checksum_ok) begin
          cmd.capture = 1'b1;
          state_next  = ST_ACK;
        end
      end
      ST_ACK: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = status.at_base ? ST_DELIVER : ST_IDLE;
        end
      end
      ST_DELIVER: begin
        out_valid    = 1'b1;
        cmd.sel_data = 1'b1;
        if (!out_stall) begin
          cmd.shift = 1'b1;
          if (status.run_end) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/srr_dpath.sv @@
// srr_dpath: window base, receive slots and result formatting
// depends on srr_pkg
`timescale 1ns / 1ps

module srr_dpath #(
  parameter int WINDOW_SIZE  = 4,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  srr_pkg::in_item_t    in_data,
  input  srr_pkg::srr_cmd_t    cmd,
  output srr_pkg::srr_status_t status,
  output srr_pkg::out_item_t   out_data
);
  import srr_pkg::*;

  localparam int IDX_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;

  logic [SEQ_W-1:0]        window_base;
  logic [WINDOW_SIZE-1:0]  slot_valid;
  logic [PAYLOAD_BITS-1:0] slot_payload [WINDOW_SIZE];
  logic [SEQ_W-1:0]        ack_seq;
  logic                    at_base;

  logic [SEQ_W-1:0]        offset;
  logic [IDX_W-1:0]        idx;
  logic                    in_window;
  logic                    do_store;
  logic [WINDOW_SIZE-1:0]  valid_after;

  assign offset    = in_data.seq_num - window_base;
  assign idx       = offset[IDX_W-1:0];
  assign in_window = ({{(32-SEQ_W){1'b0}}, offset} < 32'(WINDOW_SIZE));
  assign do_store  = in_window && !slot_valid[idx];

  // valid marks as they will stand once the head slot has gone
  assign valid_after = slot_valid >> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_base <= '0;
      slot_valid  <= '0;
      at_base     <= 1'b0;
    end else if (cmd.capture) begin
      at_base <= do_store && (offset == '0);
      if (do_store) begin
        slot_valid[idx] <= 1'b1;
      end
    end else if (cmd.shift) begin
      slot_valid  <= valid_after;
      window_base <= window_base + SEQ_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ack_seq <= in_data.seq_num;
      if (do_store) begin
        slot_payload[idx] <= in_data.payload_word[PAYLOAD_BITS-1:0];
      end
    end else if (cmd.shift) begin
      for (int i = 0; i + 1 < WINDOW_SIZE; i++) begin
        slot_payload[i] <= slot_payload[i+1];
      end
    end
  end

  assign status.at_base = at_base;
  assign status.run_end = !valid_after[0];

  always_comb begin
    if (cmd.sel_data) begin
      out_data.result_kind    = KIND_DATA;
      out_data.ack_number     = '0;
      out_data.delivered_data = DATA_W'(slot_payload[0]);
      out_data.last_of_run    = !valid_after[0];
    end else begin
      out_data.result_kind    = KIND_ACK;
      out_data.ack_number     = ack_seq;
      out_data.delivered_data = '0;
      out_data.last_of_run    = !at_base;
    end
  end

endmodule

@@ rtl/selective_repeat_receiver_core.sv @@
// selective_repeat_receiver_core: the acknowledgment appears in the cycle after the packet
// is taken, each in-order delivery follows in the cycle after the previous transfer.
// a packet yields one acknowledgment and up to WINDOW_SIZE deliveries, one result per
// cycle while out_stall is low, before the next packet is taken; a corrupted packet is
// dropped with no result. synchronous reset sets the window base to 0 and empties all
// slots; slot data is not reset. depends on srr_pkg, srr_ctrl, srr_dpath
`timescale 1ns / 1ps

module selective_repeat_receiver_core #(
  parameter int WINDOW_SIZE  = 4,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  srr_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output srr_pkg::out_item_t  out_data
);
  import srr_pkg::*;

  srr_cmd_t    cmd;
  srr_status_t status;

  srr_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .checksum_ok (in_data.checksum_ok),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cmd         (cmd),
    .status      (status)
  );

  srr_dpath #(
    .WINDOW_SIZE  (WINDOW_SIZE),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule
